[hdl/sxtb_pkg.sv]
// Shared types and constants for the S-expression tree builder.
// No dependencies; all other files in hdl/ but sxtb_ram.sv use it by scoped names.
package sxtb_pkg;

	localparam int MAX_DEPTH_DEF   = 32;
	localparam int INDEX_LIMIT_DEF = 65535;

	// result queue between the parser and the output port
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// record kinds
	localparam logic [1:0] KIND_LIST = 2'd0;
	localparam logic [1:0] KIND_ATOM = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	// error codes
	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_TOO_DEEP  = 4'd1;
	localparam logic [3:0] ERR_OPEN_TOP  = 4'd2;
	localparam logic [3:0] ERR_STRAY_CLS = 4'd3;
	localparam logic [3:0] ERR_BARE_ATOM = 4'd4;
	localparam logic [3:0] ERR_NO_CLS_QT = 4'd5;
	localparam logic [3:0] ERR_QT_IN_ATM = 4'd6;
	localparam logic [3:0] ERR_MISS_CLS  = 4'd7;
	localparam logic [3:0] ERR_TOO_LONG  = 4'd8;

	// characters
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} char_t;

	typedef struct packed {
		logic [1:0]  rec_kind;
		logic [15:0] node_index;
		logic        has_parent;
		logic [15:0] owner_index;
		logic        has_prev;
		logic [15:0] prev_index;
		logic [15:0] atom_start;
		logic [15:0] atom_end;
		logic        atom_quoted;
		logic [3:0]  error_code;
		logic [15:0] error_pos;
		logic        last;
	} rec_t;

	// up to two records produced by one request
	typedef struct packed {
		logic [1:0] count;
		rec_t       rec0;
		rec_t       rec1;
	} push_t;

endpackage

[hdl/sxtb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sxtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/sxtb_parse.sv]
// Parser core: scan state, node numbering and the open-list stack.
// Top of stack is held in registers, lower entries in an sxtb_ram; uses sxtb_pkg.
module sxtb_parse #(
	parameter int MAX_DEPTH   = sxtb_pkg::MAX_DEPTH_DEF,
	parameter int INDEX_LIMIT = sxtb_pkg::INDEX_LIMIT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            acc,
	input  sxtb_pkg::char_t char_req,
	output sxtb_pkg::push_t push
);

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_BARE   = 2'd1;
	localparam logic [1:0] MODE_QUOTED = 2'd2;

	typedef struct packed {
		logic [15:0] list_idx;
		logic        child_ok;
		logic [15:0] child_idx;
	} stk_t;

	localparam int SW = $bits(stk_t);

	function automatic sxtb_pkg::rec_t node_rec(input logic [1:0] kind,
			input logic [15:0] idx, input logic in_list, input logic [15:0] par,
			input logic cv, input logic [15:0] ch);
		sxtb_pkg::rec_t r;
		r              = '0;
		r.rec_kind     = kind;
		r.node_index   = idx;
		r.has_parent   = in_list;
		r.owner_index  = in_list ? par : 16'd0;
		r.has_prev     = in_list & cv;
		r.prev_index   = (in_list & cv) ? ch : 16'd0;
		return r;
	endfunction

	function automatic sxtb_pkg::rec_t err_rec(input logic [3:0] code, input logic [15:0] pos);
		sxtb_pkg::rec_t r;
		r            = '0;
		r.rec_kind   = sxtb_pkg::KIND_ERR;
		r.error_code = code;
		r.error_pos  = pos;
		return r;
	endfunction

	// state
	logic [15:0]   pos_q, cnt_q, ab_q;
	logic [DW-1:0] dep_q;
	logic [1:0]    mode_q;
	logic          err_q;
	stk_t          top_q;

	// next state
	logic [15:0]   ps, nc, ab;
	logic [DW-1:0] dep, dm1, dm2;
	logic [1:0]    md;
	logic          er;
	stk_t          tp;

	logic          tok, blank;
	logic          have_a, have_b;
	sxtb_pkg::rec_t rec_a, rec_b, r0, r1;
	logic [1:0]    n;

	// stack RAM
	logic          we;
	logic [AW-1:0] wa, ra;
	stk_t          wd, rd, under, byp_d_q;
	logic [SW-1:0] rd_raw;
	logic          byp_q;

	logic [7:0]  c;
	logic [15:0] pos;

	assign c     = char_req.in_byte;
	assign pos   = pos_q;
	assign blank = c inside {8'd32, [8'd9:8'd13]};
	assign rd    = stk_t'(rd_raw);
	assign under = byp_q ? byp_d_q : rd;

	always_comb begin
		ps = pos_q;  nc = cnt_q;  ab = ab_q;  dep = dep_q;
		md = mode_q; er = err_q;  tp = top_q;
		tok = 1'b0;
		have_a = 1'b0; rec_a = '0;
		have_b = 1'b0; rec_b = '0;
		we = 1'b0; wd = '0;
		dm1 = dep_q - DW'(1);
		wa = dm1[AW-1:0];

		if (char_req.end_of_input) begin
			if (!err_q) begin
				have_a = 1'b1;
				if (mode_q == MODE_QUOTED) begin
					rec_a = err_rec(sxtb_pkg::ERR_NO_CLS_QT, pos);
				end else if (mode_q == MODE_BARE || dep_q != '0) begin
					rec_a = err_rec(sxtb_pkg::ERR_MISS_CLS, pos);
				end else begin
					rec_a = '0;
					rec_a.rec_kind   = sxtb_pkg::KIND_DONE;
					rec_a.node_index = cnt_q;
				end
			end
			// rearm
			ps = '0; nc = '0; ab = '0; dep = '0; md = MODE_IDLE; er = 1'b0;
		end else if (!err_q) begin
			if (pos >= 16'(INDEX_LIMIT - 1)) begin
				have_a = 1'b1;
				rec_a  = err_rec(sxtb_pkg::ERR_TOO_LONG, pos);
				er     = 1'b1;
			end else begin
				case (mode_q)
					MODE_QUOTED: begin
						if (c == sxtb_pkg::CH_QUOTE) begin
							have_a = 1'b1;
							rec_a  = node_rec(sxtb_pkg::KIND_ATOM, nc, dep != '0,
								tp.list_idx, tp.child_ok, tp.child_idx);
							rec_a.atom_start  = ab_q;
							rec_a.atom_end    = pos;
							rec_a.atom_quoted = 1'b1;
							if (dep != '0) begin
								tp.child_ok  = 1'b1;
								tp.child_idx = nc;
							end
							nc = nc + 16'd1;
							md = MODE_IDLE;
						end
					end
					MODE_BARE: begin
						if (c == sxtb_pkg::CH_QUOTE) begin
							have_a = 1'b1;
							rec_a  = err_rec(sxtb_pkg::ERR_QT_IN_ATM, pos);
							er     = 1'b1;
						end else if (blank || c == sxtb_pkg::CH_OPEN ||
								c == sxtb_pkg::CH_CLOSE) begin
							have_a = 1'b1;
							rec_a  = node_rec(sxtb_pkg::KIND_ATOM, nc, dep != '0,
								tp.list_idx, tp.child_ok, tp.child_idx);
							rec_a.atom_start = ab_q;
							rec_a.atom_end   = pos;
							if (dep != '0) begin
								tp.child_ok  = 1'b1;
								tp.child_idx = nc;
							end
							nc  = nc + 16'd1;
							md  = MODE_IDLE;
							tok = 1'b1;
						end
					end
					default: tok = 1'b1;
				endcase

				// delimiter or token start seen between tokens
				if (tok && !blank) begin
					if (c == sxtb_pkg::CH_OPEN) begin
						have_b = 1'b1;
						if (dep >= DW'(MAX_DEPTH)) begin
							rec_b = err_rec(sxtb_pkg::ERR_TOO_DEEP, pos);
							er    = 1'b1;
						end else if (dep == '0 && pos != 16'd0) begin
							rec_b = err_rec(sxtb_pkg::ERR_OPEN_TOP, pos);
							er    = 1'b1;
						end else begin
							rec_b = node_rec(sxtb_pkg::KIND_LIST, nc, dep != '0,
								tp.list_idx, tp.child_ok, tp.child_idx);
							if (dep != '0) begin
								// spill the enclosing list, its last child now this node
								we           = 1'b1;
								wd.list_idx  = tp.list_idx;
								wd.child_ok  = 1'b1;
								wd.child_idx = nc;
							end
							tp.list_idx  = nc;
							tp.child_ok  = 1'b0;
							tp.child_idx = '0;
							nc  = nc + 16'd1;
							dep = dep + DW'(1);
						end
					end else if (c == sxtb_pkg::CH_CLOSE) begin
						if (dep == '0) begin
							have_b = 1'b1;
							rec_b  = err_rec(sxtb_pkg::ERR_STRAY_CLS, pos);
							er     = 1'b1;
						end else begin
							tp  = under;
							dep = dep - DW'(1);
						end
					end else if (dep == '0) begin
						have_b = 1'b1;
						rec_b  = err_rec(sxtb_pkg::ERR_BARE_ATOM, pos);
						er     = 1'b1;
					end else if (c == sxtb_pkg::CH_QUOTE) begin
						md = MODE_QUOTED;
						ab = pos + 16'd1;
					end else begin
						md = MODE_BARE;
						ab = pos;
					end
				end

				if (!er) begin
					ps = pos + 16'd1;
				end
			end
		end

		// pack records in order, flag the final one
		r0 = have_a ? rec_a : rec_b;
		r1 = rec_b;
		n  = {1'b0, have_a} + {1'b0, have_b};
		r0.last = (n == 2'd1);
		r1.last = 1'b1;
	end

	// read the entry just below the top of the next cycle's stack
	always_comb begin
		dm2 = (acc ? dep : dep_q) - DW'(2);
		ra  = dm2[AW-1:0];
	end

	assign push.count = acc ? n : 2'd0;
	assign push.rec0  = r0;
	assign push.rec1  = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cnt_q  <= '0;
			ab_q   <= '0;
			dep_q  <= '0;
			mode_q <= MODE_IDLE;
			err_q  <= 1'b0;
			byp_q  <= 1'b0;
		end else begin
			byp_q <= acc && we && (wa == ra);
			if (acc) begin
				pos_q  <= ps;
				cnt_q  <= nc;
				ab_q   <= ab;
				dep_q  <= dep;
				mode_q <= md;
				err_q  <= er;
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_d_q <= wd;
		if (acc) begin
			top_q <= tp;
		end
	end

	sxtb_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (acc && we),
		.waddr (wa),
		.wdata (SW'(wd)),
		.raddr (ra),
		.rdata (rd_raw)
	);

endmodule

[hdl/sxtb_outq.sv]
// Result queue: takes up to two records a cycle from the parser, hands out one while rec_stall is low.
// Uses sxtb_pkg.
module sxtb_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  sxtb_pkg::push_t push,
	output logic            full,
	output logic            rec_valid,
	input  logic            rec_stall,
	output sxtb_pkg::rec_t  rec_req
);

	localparam int AW = sxtb_pkg::OQ_AW;
	localparam int CW = sxtb_pkg::OQ_CW;

	sxtb_pkg::rec_t mem_q [sxtb_pkg::OQ_DEPTH];
	logic [AW-1:0]  wp_q, rp_q, wp1;
	logic [CW-1:0]  cnt_q;
	logic           pop;

	assign pop       = rec_valid && !rec_stall;
	assign wp1       = wp_q + AW'(1);
	assign rec_valid = (cnt_q != '0);
	assign rec_req   = mem_q[rp_q];
	// keep room for a two-record request
	assign full      = (cnt_q > CW'(sxtb_pkg::OQ_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + AW'(push.count);
			rp_q  <= rp_q + AW'(pop);
			cnt_q <= cnt_q + CW'(push.count) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wp_q] <= push.rec0;
		end
		if (push.count == 2'd2) begin
			mem_q[wp1] <= push.rec1;
		end
	end

endmodule

[hdl/sexpr_tree_builder_unit.sv]
// S-expression tree builder, top level. Records enter the result queue when a byte is
// accepted and are handed out from it. Throughput: one byte per cycle while the queue
// is not full; two-record bytes are absorbed by the four-entry queue. The open-list
// stack keeps its top in registers, lower entries in a RAM with registered read. Reset
// clears all control state; stack RAM is not cleared and stale entries go unused.
module sexpr_tree_builder_unit #(
	parameter int MAX_DEPTH   = sxtb_pkg::MAX_DEPTH_DEF,
	parameter int INDEX_LIMIT = sxtb_pkg::INDEX_LIMIT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	output logic            char_stall,
	input  sxtb_pkg::char_t char_req,
	output logic            rec_valid,
	input  logic            rec_stall,
	output sxtb_pkg::rec_t  rec_req
);

	logic            acc;
	sxtb_pkg::push_t push;

	assign acc = char_valid && !char_stall;

	sxtb_parse #(
		.MAX_DEPTH   (MAX_DEPTH),
		.INDEX_LIMIT (INDEX_LIMIT)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.char_req (char_req),
		.push     (push)
	);

	sxtb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (char_stall),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_req   (rec_req)
	);

endmodule
